FILE: rtl/core/itt_pkg.sv
// Shared constants and types for the invalidated token tracker.
package itt_pkg;

	localparam int unsigned BUCKETS_DEF = 256;
	localparam int unsigned WAYS_DEF    = 4;
	localparam int unsigned TOKEN_W     = 256;
	localparam int unsigned HASH_W      = 32;
	localparam int unsigned KILL_BIT    = 9;

	typedef enum logic [1:0] {
		K_INVAL = 2'd0,
		K_EXEC  = 2'd1,
		K_EXIT  = 2'd2
	} kind_t;

endpackage

FILE: rtl/core/invalidated_token_tracker.sv
// Top level: bounded hash set of 256-bit tokens held in a valid-row memory and a key memory.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------------
//   in      | in_valid / in_stall | kind, token_w0..token_w3, platform, sign_flags
//   out     | out_valid/out_stall | invalidated_alert, platform_critical, still_running,
//           |                     | exec_of_invalidated, entry_dropped
//
// One item at a time: in_stall stays high from accept until the update of that item, which scans k (1..WAYS)
// ways; the hash and bucket reduction dominate the time between accepts.
// The key memory delivers one way per cycle, which sets the scan length.
// After reset the valid rows are cleared one bucket per cycle, with in_stall high until all BUCKETS rows are clear.
// A result waiting in the output register holds back only the next result, not the next item.
module invalidated_token_tracker import itt_pkg::*; #(
	parameter int unsigned BUCKETS = BUCKETS_DEF,
	parameter int unsigned WAYS    = WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] token_w0,
	input  logic [63:0] token_w1,
	input  logic [63:0] token_w2,
	input  logic [63:0] token_w3,
	input  logic        platform,
	input  logic [31:0] sign_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        invalidated_alert,
	output logic        platform_critical,
	output logic        still_running,
	output logic        exec_of_invalidated,
	output logic        entry_dropped
);

	localparam int unsigned BktW   = $clog2(BUCKETS);
	localparam int unsigned WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned KeyAw  = $clog2(BUCKETS * WAYS);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_HASH = 6'b000100,
		S_READ = 6'b001000,
		S_CMP  = 6'b010000,
		S_UPD  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [BktW-1:0]    clr_q;
	logic [BktW-1:0]    bucket_q;
	logic [WayW-1:0]    way_q;
	logic [WayW-1:0]    hit_way_q;
	logic               hit_q;
	kind_t              kind_q;
	logic               platform_q;
	logic               kill_q;
	logic [TOKEN_W-1:0] tok_q;

	logic [WAYS-1:0]    vmem [BUCKETS];
	logic [TOKEN_W-1:0] kmem [BUCKETS * WAYS];
	logic [WAYS-1:0]    vrow_q;
	logic [TOKEN_W-1:0] key_q;

	logic               out_valid_q;
	logic               alert_q;
	logic               plat_crit_q;
	logic               running_q;
	logic               exec_hit_q;
	logic               dropped_q;

	logic               in_acc;
	logic               out_acc;
	logic               hash_done;
	logic [BktW-1:0]    hash_bucket;
	logic               match;
	logic               last_way;
	logic               v_re;
	logic               v_we;
	logic [BktW-1:0]    v_waddr;
	logic [WAYS-1:0]    v_wdata;
	logic               k_re;
	logic               k_we;
	logic [KeyAw-1:0]   k_raddr;
	logic [KeyAw-1:0]   k_waddr;
	logic [WayW-1:0]    rd_way;
	logic               free_found;
	logic [WayW-1:0]    free_way;
	logic               upd_go;
	logic               is_inval;
	logic               do_insert;
	logic               do_remove;
	logic               drop_now;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	itt_bucket_hash #(
		.BUCKETS(BUCKETS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.token  (tok_q),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	assign match    = vrow_q[way_q] && (key_q == tok_q);
	assign last_way = (way_q == WayW'(WAYS - 1));

	// lowest-numbered free way wins
	always_comb begin
		free_found = 1'b0;
		free_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!vrow_q[w]) begin
				free_found = 1'b1;
				free_way   = WayW'(w);
			end
		end
	end

	assign upd_go    = (state_q == S_UPD) && !(out_valid_q && out_stall);
	assign is_inval  = (kind_q == K_INVAL);
	assign do_insert = is_inval && !hit_q && free_found;
	assign drop_now  = is_inval && !hit_q && !free_found;
	assign do_remove = ((kind_q == K_EXEC) || (kind_q == K_EXIT)) && hit_q;

	// memory ports
	assign v_re   = (state_q == S_READ);
	assign rd_way = (state_q == S_READ) ? '0 : WayW'(way_q + 1'b1);
	assign k_re   = (state_q == S_READ) || ((state_q == S_CMP) && !match && !last_way);
	assign k_raddr = KeyAw'(bucket_q) * KeyAw'(WAYS) + KeyAw'(rd_way);
	assign k_we    = upd_go && do_insert;
	assign k_waddr = KeyAw'(bucket_q) * KeyAw'(WAYS) + KeyAw'(free_way);

	always_comb begin
		v_we    = 1'b0;
		v_waddr = bucket_q;
		v_wdata = vrow_q;
		if (state_q == S_CLR) begin
			v_we    = 1'b1;
			v_waddr = clr_q;
			v_wdata = '0;
		end else if (upd_go && do_insert) begin
			v_we    = 1'b1;
			v_wdata = vrow_q | (WAYS'(1) << free_way);
		end else if (upd_go && do_remove) begin
			v_we    = 1'b1;
			v_wdata = vrow_q & ~(WAYS'(1) << hit_way_q);
		end
	end

	always_ff @(posedge clk) begin
		if (v_we)
			vmem[v_waddr] <= v_wdata;
		if (v_re)
			vrow_q <= vmem[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (k_we)
			kmem[k_waddr] <= tok_q;
		if (k_re)
			key_q <= kmem[k_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			way_q     <= '0;
			hit_q     <= 1'b0;
			hit_way_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BktW'(BUCKETS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_HASH;
						hit_q   <= 1'b0;
					end
				end
				S_HASH: begin
					if (hash_done)
						state_q <= S_READ;
				end
				S_READ: begin
					way_q   <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (match) begin
						hit_q     <= 1'b1;
						hit_way_q <= way_q;
						state_q   <= S_UPD;
					end else if (last_way) begin
						state_q <= S_UPD;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				S_UPD: begin
					if (upd_go)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q     <= kind_t'(kind);
			platform_q <= platform;
			kill_q     <= sign_flags[KILL_BIT];
			tok_q      <= {token_w3, token_w2, token_w1, token_w0};
		end
		if ((state_q == S_HASH) && hash_done)
			bucket_q <= hash_bucket;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			alert_q     <= is_inval;
			plat_crit_q <= is_inval && platform_q;
			running_q   <= is_inval && !kill_q;
			exec_hit_q  <= (kind_q == K_EXEC) && hit_q;
			dropped_q   <= drop_now;
		end
	end

	assign out_valid           = out_valid_q;
	assign invalidated_alert   = alert_q;
	assign platform_critical   = plat_crit_q;
	assign still_running       = running_q;
	assign exec_of_invalidated = exec_hit_q;
	assign entry_dropped       = dropped_q;

`ifndef SYNTHESIS
	a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == S_HASH))
		else $error("hash finished outside the hash wait");

	a_insert_free_way: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && do_insert) |-> !vrow_q[free_way])
		else $error("insert targets an occupied way");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && drop_now) |-> (&vrow_q))
		else $error("item dropped while bucket has a free way");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_UPD))
		else $error("result raised without a table update");
`endif

endmodule

FILE: rtl/core/itt_bucket_hash.sv
// Byte-wise h*31+byte token hash followed by a reciprocal-multiply reduction to a bucket index.
module itt_bucket_hash import itt_pkg::*; #(
	parameter int unsigned BUCKETS = BUCKETS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [TOKEN_W-1:0]           token,
	output logic                         done,
	output logic [$clog2(BUCKETS)-1:0]   bucket
);

	localparam int unsigned BktW       = $clog2(BUCKETS);
	localparam int unsigned HashSteps  = TOKEN_W / 16;
	localparam int unsigned CntW       = $clog2(HashSteps);
	// floor(h / BUCKETS) = (t + ((h - t) >> 1)) >> (BktW - 1), t = (h * RecipM) >> HASH_W
	localparam longint unsigned RecipFull =
		(((64'd1 << HASH_W) * ((64'd1 << BktW) - 64'(BUCKETS))) / 64'(BUCKETS)) + 64'd1;
	localparam logic [HASH_W-1:0] RecipM = HASH_W'(RecipFull);
	localparam logic [HASH_W-1:0] BktC   = HASH_W'(BUCKETS);

	typedef enum logic [4:0] {
		H_IDLE = 5'b00001,
		H_HASH = 5'b00010,
		H_MUL  = 5'b00100,
		H_QUO  = 5'b01000,
		H_REM  = 5'b10000
	} hstate_t;

	hstate_t             hstate_q;
	logic [CntW-1:0]     cnt_q;
	logic [HASH_W-1:0]   h_q;
	logic [HASH_W-1:0]   t_q;
	logic [HASH_W-1:0]   q_q;
	logic [BktW-1:0]     r_q;
	logic                done_q;
	logic [15:0]         pair;
	logic [HASH_W-1:0]   h_mid;
	logic [HASH_W-1:0]   h_next;
	logic [2*HASH_W-1:0] prod;
	logic [HASH_W-1:0]   q_next;
	logic [HASH_W-1:0]   r_full;

	// two bytes per cycle, lower byte index first
	assign pair   = token[{cnt_q, 4'b0000} +: 16];
	assign h_mid  = (h_q << 5) - h_q + {{(HASH_W-8){1'b0}}, pair[7:0]};
	assign h_next = (h_mid << 5) - h_mid + {{(HASH_W-8){1'b0}}, pair[15:8]};

	// quotient by reciprocal, then remainder, one step per cycle
	assign prod   = {{HASH_W{1'b0}}, h_q} * {{HASH_W{1'b0}}, RecipM};
	assign q_next = (t_q + ((h_q - t_q) >> 1)) >> (BktW - 1);
	assign r_full = h_q - q_q * BktC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstate_q <= H_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (hstate_q)
				H_IDLE: begin
					if (start) begin
						hstate_q <= H_HASH;
						cnt_q    <= '0;
					end
				end
				H_HASH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(HashSteps - 1)) begin
						hstate_q <= H_MUL;
						cnt_q    <= '0;
					end
				end
				H_MUL: begin
					hstate_q <= H_QUO;
				end
				H_QUO: begin
					hstate_q <= H_REM;
				end
				H_REM: begin
					hstate_q <= H_IDLE;
					done_q   <= 1'b1;
				end
				default: begin
					hstate_q <= H_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (hstate_q)
			H_IDLE: begin
				h_q <= '0;
			end
			H_HASH: begin
				h_q <= h_next;
			end
			H_MUL: begin
				t_q <= prod[2*HASH_W-1:HASH_W];
			end
			H_QUO: begin
				q_q <= q_next;
			end
			H_REM: begin
				r_q <= r_full[BktW-1:0];
			end
			default: begin
				h_q <= h_q;
			end
		endcase
	end

	assign done   = done_q;
	assign bucket = r_q;

endmodule
